// ===== rtl/rotor_effectiveness_column_top_assert.svh =====
// Assertion macros for the rotor effectiveness column top level.
`ifndef ROTOR_EFFECTIVENESS_COLUMN_TOP_ASSERT_SVH
`define ROTOR_EFFECTIVENESS_COLUMN_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define REC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rotor effectiveness column check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define REC_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rotor effectiveness column check failed");

`endif

// ===== rtl/rec_pkg.sv =====
// Shared types, constants and rounding helper for the rotor effectiveness column.
`default_nettype none
package rec_pkg;

  localparam int MAX_ROTORS = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W = 5;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROTORS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_UP_ONLY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_OFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLLECTIVE = 3'd4;

  localparam int TORQUE_SHIFT = 34;
  localparam int FORCE_SHIFT = 22;

  typedef struct packed {
    logic [3:0]         rotor_number;
    logic               rotor_on;
    logic               first_rotor;
    logic               final_rotor;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] thrust_coef;
    logic signed [15:0] drag_ratio;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         column_number;
    logic               column_active;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [4:0]         active_total;
    logic               matrix_done;
  } out_item_t;

  typedef struct packed {
    logic [4:0] num_rotors;
    logic       drag_torque_off;
    logic       drag_torque_up_only;
    logic       yaw_entry_off;
    logic       collective_thrust_mode;
  } cfg_t;

  // Request after classification: active decided, drag ratio already forced
  // to zero when drag torque is switched off.
  typedef struct packed {
    logic [3:0]         rotor_number;
    logic               active;
    logic               first_rotor;
    logic               final_rotor;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] thrust_coef;
    logic signed [15:0] drag_ratio;
  } cls_item_t;

  // Drop sh fraction bits, round half away from zero, saturate to 32 bits.
  function automatic logic [31:0] to_q16(logic signed [65:0] v, int sh);
    logic [65:0] mag;
    logic [65:0] rnd;
    logic [31:0] res;
    mag = v[65] ? 66'(-v) : 66'(v);
    rnd = (mag + (66'd1 << (sh - 1))) >> sh;
    if (v[65]) begin
      if (rnd > 66'h0_8000_0000) begin
        rnd = 66'h0_8000_0000;
      end
      res = 32'(66'd0 - rnd);
    end else begin
      if (rnd > 66'h0_7FFF_FFFF) begin
        rnd = 66'h0_7FFF_FFFF;
      end
      res = rnd[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rec_front.sv =====
// Front end: takes input requests, classifies them and hands them to the queue.
`default_nettype none
module rec_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rec_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rec_pkg::in_item_t in_data,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output rec_pkg::cls_item_t     q_data
);

  logic               hold_valid;
  rec_pkg::cls_item_t hold;
  rec_pkg::cls_item_t cls;
  logic               in_range;

  // A rotor counts only below both the programmed count and the build limit.
  assign in_range = (32'(in_data.rotor_number) < 32'(cfg.num_rotors)) &&
                    (32'(in_data.rotor_number) < rec_pkg::MAX_ROTORS);

  always_comb begin
    cls.rotor_number = in_data.rotor_number;
    cls.active = in_data.rotor_on && in_range && (in_data.thrust_coef != 16'sd0) &&
                 ((in_data.axis_x != 16'sd0) || (in_data.axis_y != 16'sd0) ||
                  (in_data.axis_z != 16'sd0));
    cls.first_rotor = in_data.first_rotor;
    cls.final_rotor = in_data.final_rotor;
    cls.axis_x = in_data.axis_x;
    cls.axis_y = in_data.axis_y;
    cls.axis_z = in_data.axis_z;
    cls.pos_x = in_data.pos_x;
    cls.pos_y = in_data.pos_y;
    cls.pos_z = in_data.pos_z;
    cls.thrust_coef = in_data.thrust_coef;
    cls.drag_ratio = cfg.drag_torque_off ? 16'sd0 : in_data.drag_ratio;
  end

  assign in_stall = hold_valid && !q_ready;
  assign q_valid = hold_valid;
  assign q_data = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rec_queue.sv =====
// Short request queue between the front end and the arithmetic back end.
`default_nettype none
module rec_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire rec_pkg::cls_item_t push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output rec_pkg::cls_item_t      pop_data
);

  rec_pkg::cls_item_t               slots [rec_pkg::QUEUE_DEPTH];
  logic [rec_pkg::QPTR_W-1:0] wr_ptr;
  logic [rec_pkg::QPTR_W-1:0] rd_ptr;
  logic [rec_pkg::QCNT_W-1:0] count;
  logic                       push;
  logic                       pop;

  assign push_ready = (count != rec_pkg::QCNT_W'(rec_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == rec_pkg::QPTR_W'(rec_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == rec_pkg::QPTR_W'(rec_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rec_back.sv =====
// Back end: norm, unit axis, column products, rounding and the output register.
`default_nettype none
module rec_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rec_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rec_pkg::cls_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rec_pkg::out_item_t      out_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQR   = 4'd1;
  localparam logic [3:0] ST_SUMS  = 4'd2;
  localparam logic [3:0] ST_ROOT  = 4'd3;
  localparam logic [3:0] ST_DINIT = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_MUL1  = 4'd6;
  localparam logic [3:0] ST_SUMT  = 4'd7;
  localparam logic [3:0] ST_MUL2  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0]                 state;
  logic [rec_pkg::STEP_W-1:0] step;
  rec_pkg::cls_item_t         item;
  logic [4:0]                 active_counter;

  logic signed [15:0] ax [3];
  logic signed [15:0] px [3];
  logic [31:0]        sq [3];
  logic [31:0]        xs;
  logic [35:0]        rem_s;
  logic [31:0]        root;
  logic [31:0]        drem [3];
  logic [31:0]        dq [3];
  logic               neg [3];
  logic signed [31:0] u [3];
  logic signed [47:0] pa [3];
  logic signed [47:0] pb [3];
  logic signed [47:0] pc [3];
  logic signed [47:0] f [3];
  logic signed [49:0] t [3];
  logic signed [65:0] kt_t [3];

  logic [35:0]        rem_sh;
  logic [35:0]        root_trial;
  logic [32:0]        r2 [3];
  logic               ge [3];
  logic [15:0]        mag [3];
  logic [61:0]        dvd [3];
  logic [31:0]        au [3];
  logic               up;
  logic signed [15:0] km_eff;
  logic [31:0]        tq [3];
  logic [31:0]        fr [3];
  logic signed [31:0] ktw;
  logic [4:0]         cnt_base;
  logic [4:0]         cnt_new;
  logic               load;
  rec_pkg::out_item_t res;

  assign ax[0] = item.axis_x;
  assign ax[1] = item.axis_y;
  assign ax[2] = item.axis_z;
  assign px[0] = item.pos_x;
  assign px[1] = item.pos_y;
  assign px[2] = item.pos_z;

  assign in_ready = (state == ST_IDLE);

  // One root digit per cycle from two bits of S * 2^32.
  assign rem_sh = {rem_s[33:0], xs[31:30]};
  assign root_trial = {2'b00, root, 2'b01};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2[i] = {drem[i], dq[i][31]};
      ge[i] = (r2[i] >= {1'b0, root});
      mag[i] = ax[i][15] ? 16'(-ax[i]) : 16'(ax[i]);
      dvd[i] = {mag[i], 46'd0} + 62'(root >> 1);
      u[i] = neg[i] ? -signed'(dq[i]) : signed'(dq[i]);
      au[i] = u[i][31] ? 32'(-u[i]) : 32'(u[i]);
    end
  end

  // Pointing up: both side components below 0.1 and z below -0.5.
  assign up = ((36'(au[0]) * 36'd10) < (36'd1 << 30)) &&
              ((36'(au[1]) * 36'd10) < (36'd1 << 30)) &&
              (u[2] < -32'sd536870912);
  assign km_eff = (cfg.drag_torque_up_only && !up) ? 16'sd0 : item.drag_ratio;

  assign ktw = 32'(item.thrust_coef);
  assign cnt_base = item.first_rotor ? 5'd0 : active_counter;
  assign cnt_new = (item.active && (cnt_base != 5'd31)) ? cnt_base + 5'd1 : cnt_base;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tq[i] = rec_pkg::to_q16(kt_t[i], rec_pkg::TORQUE_SHIFT);
      fr[i] = rec_pkg::to_q16(66'(f[i]), rec_pkg::FORCE_SHIFT);
    end
    res.column_number = item.rotor_number;
    res.column_active = item.active;
    res.torque_x = '0;
    res.torque_y = '0;
    res.torque_z = '0;
    res.force_x = '0;
    res.force_y = '0;
    res.force_z = '0;
    res.active_total = cnt_new;
    res.matrix_done = item.final_rotor;
    if (item.active) begin
      res.torque_x = tq[0];
      res.torque_y = tq[1];
      res.torque_z = cfg.yaw_entry_off ? 32'sd0 : tq[2];
      if (cfg.collective_thrust_mode) begin
        res.force_z = -(ktw <<< 8);
      end else begin
        res.force_x = fr[0];
        res.force_y = fr[1];
        res.force_z = fr[2];
      end
    end
  end

  assign load = (state == ST_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      active_counter <= '0;
      step <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= in_data.active ? ST_SQR : ST_FIN;
          end
        end
        ST_SQR: begin
          state <= ST_SUMS;
        end
        ST_SUMS: begin
          step <= '0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          step <= step + 1'b1;
          if (step == rec_pkg::STEP_W'(rec_pkg::ROOT_STEPS - 1)) begin
            state <= ST_DINIT;
          end
        end
        ST_DINIT: begin
          step <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == rec_pkg::STEP_W'(rec_pkg::DIV_STEPS - 1)) begin
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          state <= ST_SUMT;
        end
        ST_SUMT: begin
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (load) begin
            active_counter <= cnt_new;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
    if (load) begin
      out_data <= res;
    end
    case (state)
      ST_SQR: begin
        for (int i = 0; i < 3; i++) begin
          sq[i] <= unsigned'(32'(ax[i]) * 32'(ax[i]));
        end
      end
      ST_SUMS: begin
        xs <= sq[0] + sq[1] + sq[2];
        rem_s <= '0;
        root <= '0;
      end
      ST_ROOT: begin
        xs <= {xs[29:0], 2'b00};
        if (rem_sh >= root_trial) begin
          rem_s <= rem_sh - root_trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem_s <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
      end
      ST_DINIT: begin
        for (int i = 0; i < 3; i++) begin
          drem[i] <= 32'(dvd[i][61:32]);
          dq[i] <= dvd[i][31:0];
          neg[i] <= ax[i][15];
        end
      end
      ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          drem[i] <= ge[i] ? 32'(r2[i] - {1'b0, root}) : r2[i][31:0];
          dq[i] <= {dq[i][30:0], ge[i]};
        end
      end
      ST_MUL1: begin
        pa[0] <= px[1] * u[2];
        pb[0] <= px[2] * u[1];
        pa[1] <= px[2] * u[0];
        pb[1] <= px[0] * u[2];
        pa[2] <= px[0] * u[1];
        pb[2] <= px[1] * u[0];
        for (int i = 0; i < 3; i++) begin
          pc[i] <= km_eff * u[i];
          f[i] <= item.thrust_coef * u[i];
        end
      end
      ST_SUMT: begin
        for (int i = 0; i < 3; i++) begin
          t[i] <= pa[i] - pb[i] - pc[i];
        end
      end
      ST_MUL2: begin
        for (int i = 0; i < 3; i++) begin
          kt_t[i] <= item.thrust_coef * t[i];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/rotor_effectiveness_column_top.sv =====
// An active column runs through every arithmetic state of the back end; an inactive one
// goes straight to its output state. A request first passes the front end register and
// the queue. The back end takes no new request until it is idle again, paced by the
// 32-step square root and the 32-step divide lanes.
// The front end and a two-entry queue accept up to three requests while it works.
// Reset (rst, synchronous, active high) clears the configuration registers, the active
// count, the queue and both handshake stages; there is no clearing pass.
`default_nettype none
module rotor_effectiveness_column_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire rec_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output rec_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rec_pkg::CFG_DATA_W-1:0]  cfg_data
);

  `include "rotor_effectiveness_column_top_assert.svh"

  // Configuration registers. The user must write them only while the block is idle; the
  // block does not enforce this. Both halves read them directly. Unknown indices are dropped.
  rec_pkg::cfg_t      cfg;
  logic               q_push_valid;
  logic               q_push_ready;
  rec_pkg::cls_item_t q_push_data;
  logic               q_pop_valid;
  logic               q_pop_ready;
  rec_pkg::cls_item_t q_pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rec_pkg::REG_NUM_ROTORS: begin
          cfg.num_rotors <= cfg_data;
        end
        rec_pkg::REG_DRAG_OFF: begin
          cfg.drag_torque_off <= cfg_data[0];
        end
        rec_pkg::REG_DRAG_UP_ONLY: begin
          cfg.drag_torque_up_only <= cfg_data[0];
        end
        rec_pkg::REG_YAW_OFF: begin
          cfg.yaw_entry_off <= cfg_data[0];
        end
        rec_pkg::REG_COLLECTIVE: begin
          cfg.collective_thrust_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // The front end decides whether a column is active and registers the request.
  rec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_push_valid),
    .q_ready  (q_push_ready),
    .q_data   (q_push_data)
  );

  // The queue lets the front end keep accepting while the back end iterates.
  rec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  // The back end computes the norm, the unit axis and the column, keeps the
  // running active count and owns the output register.
  rec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_pop_valid),
    .in_ready  (q_pop_ready),
    .in_data   (q_pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An inactive column carries only zero entries.
  `REC_ASSERT_IMP(a_inactive_zero, out_valid && !out_data.column_active,
    (out_data.torque_x == 32'sd0) && (out_data.torque_y == 32'sd0) &&
    (out_data.torque_z == 32'sd0) && (out_data.force_x == 32'sd0) &&
    (out_data.force_y == 32'sd0) && (out_data.force_z == 32'sd0))

  // An active column is always counted.
  `REC_ASSERT_IMP(a_active_counted, out_valid && out_data.column_active,
    out_data.active_total != 5'd0)

  // With the yaw entry switched off no result shows a yaw torque.
  `REC_ASSERT_IMP(a_yaw_off, out_valid && cfg.yaw_entry_off,
    out_data.torque_z == 32'sd0)

  // A request held by the front end with a full queue keeps the input stalled.
  `REC_ASSERT_NXT(a_front_holds, q_push_valid && !q_push_ready && !q_pop_ready,
    q_push_valid)

endmodule
`default_nettype wire

// ===== tb/rotor_effectiveness_column_top_test.sv =====
// Self-checking testbench for the rotor effectiveness column top level.
`timescale 1ns / 1ps
`default_nettype none
module rotor_effectiveness_column_top_test;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rec_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rec_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rec_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rec_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Requests waiting for the driver, and the columns the predictor expects back.
  rec_pkg::in_item_t pending_rotors[$];
  rec_pkg::out_item_t expected_columns[$];

  // Predictor copy of the registers and of the active column count.
  rec_pkg::cfg_t shadow_cfg = '0;
  logic [4:0] shadow_active = '0;

  // Idling percentages of the current phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int mismatches = 0;
  int cycles = 0;

  rotor_effectiveness_column_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Bitwise integer square root of a 64-bit value, truncated.
  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One axis component scaled to a Q2.30 unit component, rounded half away from zero.
  function automatic longint unit_component(longint a, longint unsigned norm);
    longint unsigned mag;
    longint unsigned q;
    mag = (a < 0 ? -a : a);
    mag = mag << 46;
    q = (mag + (norm >> 1)) / norm;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Reduce to Q16.16 by dropping sh fraction bits, rounding half away from zero,
  // then saturate to the signed 32-bit range.
  function automatic logic [31:0] reduce_q16(longint v, int sh);
    longint unsigned mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(-mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Works out the column for one accepted rotor request and advances the count.
  function automatic rec_pkg::out_item_t effectiveness_column(rec_pkg::in_item_t r);
    rec_pkg::out_item_t c;
    longint ax, ay, az, px, py, pz, kt, km;
    longint ux, uy, uz, tx, ty, tz;
    longint unsigned s, norm, limit;
    logic active;
    logic up;
    ax = 64'(r.axis_x); ay = 64'(r.axis_y); az = 64'(r.axis_z);
    px = 64'(r.pos_x); py = 64'(r.pos_y); pz = 64'(r.pos_z);
    kt = 64'(r.thrust_coef); km = 64'(r.drag_ratio);
    limit = (64'(shadow_cfg.num_rotors) < 64'(rec_pkg::MAX_ROTORS)) ?
            64'(shadow_cfg.num_rotors) : 64'(rec_pkg::MAX_ROTORS);
    s = ax * ax + ay * ay + az * az;
    active = r.rotor_on && (64'(r.rotor_number) < limit) && s != 0 && kt != 0;
    if (r.first_rotor) shadow_active = '0;
    c = '0;
    if (active) begin
      norm = root64(s << 32);
      ux = unit_component(ax, norm);
      uy = unit_component(ay, norm);
      uz = unit_component(az, norm);
      if (shadow_cfg.drag_torque_off) km = 0;
      if (shadow_cfg.drag_torque_up_only) begin
        up = (ux < 0 ? -ux : ux) * 10 < (64'sd1 << 30) &&
             (uy < 0 ? -uy : uy) * 10 < (64'sd1 << 30) && uz < -(64'sd1 << 29);
        if (!up) km = 0;
      end
      tx = py * uz - pz * uy - km * ux;
      ty = pz * ux - px * uz - km * uy;
      tz = px * uy - py * ux - km * uz;
      c.torque_x = reduce_q16(kt * tx, rec_pkg::TORQUE_SHIFT);
      c.torque_y = reduce_q16(kt * ty, rec_pkg::TORQUE_SHIFT);
      c.torque_z = shadow_cfg.yaw_entry_off ? '0 : reduce_q16(kt * tz, rec_pkg::TORQUE_SHIFT);
      if (shadow_cfg.collective_thrust_mode) begin
        c.force_z = 32'(-kt * 256);
      end else begin
        c.force_x = reduce_q16(kt * ux, rec_pkg::FORCE_SHIFT);
        c.force_y = reduce_q16(kt * uy, rec_pkg::FORCE_SHIFT);
        c.force_z = reduce_q16(kt * uz, rec_pkg::FORCE_SHIFT);
      end
      if (shadow_active < 5'd31) shadow_active = shadow_active + 5'd1;
    end
    c.column_number = r.rotor_number;
    c.column_active = active;
    c.active_total = shadow_active;
    c.matrix_done = r.final_rotor;
    return c;
  endfunction

  // Driver: a request leaves the bus only once it has been taken, and the
  // prediction is made on the very edge that takes it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_columns.push_back(effectiveness_column(in_data));
      if (pending_rotors.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_rotors.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Monitor: every column taken is checked against the oldest expectation.
  always @(posedge clk) begin
    rec_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_columns.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected column %p", out_data);
        end else begin
          want = expected_columns.pop_front();
          compare_field("column_number", 64'(want.column_number),
                        64'(out_data.column_number));
          compare_field("column_active", 64'(want.column_active),
                        64'(out_data.column_active));
          compare_field("torque_x", 64'(want.torque_x), 64'(out_data.torque_x));
          compare_field("torque_y", 64'(want.torque_y), 64'(out_data.torque_y));
          compare_field("torque_z", 64'(want.torque_z), 64'(out_data.torque_z));
          compare_field("force_x", 64'(want.force_x), 64'(out_data.force_x));
          compare_field("force_y", 64'(want.force_y), 64'(out_data.force_y));
          compare_field("force_z", 64'(want.force_z), 64'(out_data.force_z));
          compare_field("active_total", 64'(want.active_total),
                        64'(out_data.active_total));
          compare_field("matrix_done", 64'(want.matrix_done), 64'(out_data.matrix_done));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Register write; the predictor copy follows on the edge that takes it.
  task automatic write_reg(logic [rec_pkg::CFG_IDX_W-1:0] idx,
                           logic [rec_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rec_pkg::REG_NUM_ROTORS: shadow_cfg.num_rotors = value;
      rec_pkg::REG_DRAG_OFF: shadow_cfg.drag_torque_off = value[0];
      rec_pkg::REG_DRAG_UP_ONLY: shadow_cfg.drag_torque_up_only = value[0];
      rec_pkg::REG_YAW_OFF: shadow_cfg.yaw_entry_off = value[0];
      rec_pkg::REG_COLLECTIVE: shadow_cfg.collective_thrust_mode = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random 5-bit write for a one-bit register, so that the upper bits are ignored.
  function automatic logic [rec_pkg::CFG_DATA_W-1:0] flag_value();
    return rec_pkg::CFG_DATA_W'($urandom);
  endfunction

  task automatic set_config(logic [4:0] count, logic drag_off, logic up_only,
                            logic yaw_off, logic collective);
    write_reg(rec_pkg::REG_NUM_ROTORS, count);
    write_reg(rec_pkg::REG_DRAG_OFF, {4'(flag_value() >> 1), drag_off});
    write_reg(rec_pkg::REG_DRAG_UP_ONLY, {4'(flag_value() >> 1), up_only});
    write_reg(rec_pkg::REG_YAW_OFF, {4'(flag_value() >> 1), yaw_off});
    write_reg(rec_pkg::REG_COLLECTIVE, {4'(flag_value() >> 1), collective});
  endtask

  // Waits until every queued request has gone and every column has come back.
  task automatic drain();
    while (pending_rotors.size() != 0 || in_valid || expected_columns.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] any16();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 40)) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // Well-formed rotor with random geometry; some point straight up with a small tilt.
  function automatic rec_pkg::in_item_t random_rotor(int num, logic first, logic last);
    rec_pkg::in_item_t r;
    r.rotor_number = 4'(num);
    r.rotor_on = ($urandom_range(9) != 0);
    r.first_rotor = first;
    r.final_rotor = last;
    if ($urandom_range(2) == 0) begin
      r.axis_x = 16'($urandom_range(0, 600)) - 16'sd300;
      r.axis_y = 16'($urandom_range(0, 600)) - 16'sd300;
      r.axis_z = -16'sd1 - 16'($urandom_range(1000, 32767));
    end else begin
      r.axis_x = any16();
      r.axis_y = any16();
      r.axis_z = any16();
    end
    r.pos_x = any16();
    r.pos_y = any16();
    r.pos_z = any16();
    r.thrust_coef = ($urandom_range(19) == 0) ? 16'sd0 : any16();
    r.drag_ratio = any16();
    return r;
  endfunction

  initial begin
    rec_pkg::in_item_t r;
    int n;
    int phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: field extremes, each special case and every register.
    set_config(5'd16, 1'b0, 1'b0, 1'b0, 1'b0);
    r = '0;
    r.rotor_on = 1'b1; r.first_rotor = 1'b1;
    r.axis_z = -16'sd1000; r.pos_x = 16'sh7FFF; r.pos_y = 16'sh8000;
    r.pos_z = 16'sh7FFF; r.thrust_coef = 16'sh7FFF; r.drag_ratio = 16'sh8000;
    pending_rotors.push_back(r);
    r.first_rotor = 1'b0;
    r.axis_x = 16'sh8000; r.axis_y = 16'sh8000; r.axis_z = 16'sh8000;
    r.thrust_coef = 16'sh8000; r.drag_ratio = 16'sh7FFF;
    pending_rotors.push_back(r);
    r.axis_x = 16'sh7FFF; r.axis_y = 16'sh7FFF; r.axis_z = 16'sh7FFF;
    r.rotor_number = 4'd15; r.final_rotor = 1'b1;
    pending_rotors.push_back(r);
    r.final_rotor = 1'b0;
    // Zero axis, zero thrust coefficient and a rotor switched off are all inactive.
    r.axis_x = '0; r.axis_y = '0; r.axis_z = '0;
    pending_rotors.push_back(r);
    r.axis_x = 16'sd1; r.thrust_coef = '0;
    pending_rotors.push_back(r);
    r.thrust_coef = 16'sd1; r.rotor_on = 1'b0;
    pending_rotors.push_back(r);
    r.rotor_on = 1'b1; r.pos_x = '0; r.pos_y = '0; r.pos_z = '0;
    pending_rotors.push_back(r);
    drain();

    // Count above the parameter still leaves rotor 15 as the last live index,
    // and three of the flag combinations, the last for an upright and a tilted rotor.
    set_config(5'd31, 1'b1, 1'b0, 1'b1, 1'b1);
    for (int i = 0; i < 4; i++) pending_rotors.push_back(random_rotor(15 - i, i == 0, i == 3));
    drain();
    set_config(5'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 2; i++) pending_rotors.push_back(random_rotor(i, 1'b0, 1'b0));
    drain();
    set_config(5'd17, 1'b0, 1'b1, 1'b0, 1'b1);
    // Stray register indexes must leave the registers alone.
    write_reg(3'd5, 5'h1F);
    write_reg(3'd6, 5'h00);
    write_reg(3'd7, 5'h15);
    r = random_rotor(3, 1'b0, 1'b1);
    r.rotor_on = 1'b1; r.axis_x = 16'sd1; r.axis_y = -16'sd1; r.axis_z = -16'sd30000;
    r.thrust_coef = 16'sd256;
    pending_rotors.push_back(r);
    r.axis_x = 16'sd20000;
    pending_rotors.push_back(r);
    drain();

    // Random part: whole matrices with random content under changing settings
    // and idling, and one long run without restarts to fill the counter.
    n = 0;
    phase = 0;
    while (n < 450) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 46; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 46; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (phase % 3 == 0) set_config(5'd16, 1'b0, 1'b0, 1'b0, 1'b0);
      else set_config(($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16)),
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
      if (phase == 2) begin
        for (int i = 0; i < 40; i++) pending_rotors.push_back(random_rotor(i % 16, 1'b0, 1'b0));
        n += 40;
      end else begin
        for (int m = 0; m < 4; m++) begin
          int size;
          size = $urandom_range(1, 16);
          for (int i = 0; i < size; i++) begin
            r = random_rotor(i, i == 0, i == size - 1);
            // A little noise: stray indexes and broken framing.
            if ($urandom_range(15) == 0) r.rotor_number = 4'($urandom);
            if ($urandom_range(15) == 0) r.first_rotor = ~r.first_rotor;
            if ($urandom_range(15) == 0) r.final_rotor = ~r.final_rotor;
            pending_rotors.push_back(r);
          end
          n += size;
        end
      end
      // The sender holds off here until every column of the phase is back.
      drain();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_columns.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/rec_pkg.sv
rtl/rec_front.sv
rtl/rec_queue.sv
rtl/rec_back.sv
rtl/rotor_effectiveness_column_top.sv
tb/rotor_effectiveness_column_top_test.sv
